// ===== hdl/zone_step_steering_sequencer_defines.svh =====
// Assertion helpers for the sequencer modules, included by zsss_back.
// Each helper expects clk and rst_n in scope.
`ifndef ZONE_STEP_STEERING_SEQUENCER_DEFINES_SVH
`define ZONE_STEP_STEERING_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define ZSSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ZSSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/zsss_pkg.sv =====
package zsss_pkg;

    // Step counter width
    localparam int COUNT_BITS = 8;

    // Queue between classifier and executor
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // Field widths
    localparam int X_W     = 17;
    localparam int SEC_W   = 32;
    localparam int DUTY_W  = 8;
    localparam int TICKS_W = 21;
    localparam int LIM_W   = 8;
    localparam int CMD_W   = 32;
    localparam int IN_TDATA_W = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEER_DUTY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RIGHT = 3'd5;

    // Register reset values
    localparam logic [DUTY_W-1:0]  DUTY_RESET        = 8'd185;
    localparam logic [TICKS_W-1:0] TICKS_RESET       = 21'd39062;
    localparam logic [LIM_W-1:0]   STALE_RESET       = 8'd3;
    localparam logic [LIM_W-1:0]   HOLD_RESET        = 8'd3;
    localparam logic [X_W-1:0]     SEARCH_LEFT_RESET = 17'd6554;
    localparam logic [X_W-1:0]     SEARCH_RIGHT_RESET = 17'd58982;

    // Direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;

    // Zone boundaries on raw Q1.16 x
    localparam logic [X_W-1:0] CENTER_LO = 17'd32441;
    localparam logic [X_W-1:0] CENTER_HI = 17'd33095;
    localparam logic [X_W-1:0] ZONE_B1   = 17'd8192;
    localparam logic [X_W-1:0] ZONE_B2   = 17'd16384;
    localparam logic [X_W-1:0] ZONE_B3   = 17'd24576;
    localparam logic [X_W-1:0] ZONE_B5   = 17'd40960;
    localparam logic [X_W-1:0] ZONE_B6   = 17'd49152;
    localparam logic [X_W-1:0] ZONE_B7   = 17'd57344;
    localparam logic [X_W-1:0] X_ONE     = 17'd65536;

    typedef struct packed {
        logic [DUTY_W-1:0]  steer_duty;
        logic [TICKS_W-1:0] pulse_ticks;
        logic [LIM_W-1:0]   stale_limit;
        logic [LIM_W-1:0]   stop_hold;
        logic [X_W-1:0]     search_left;
        logic [X_W-1:0]     search_right;
    } cfg_t;

    // One classified tick
    typedef struct packed {
        logic              fresh;
        logic signed [3:0] zone;
        logic [2:0]        zone_mag;
        logic              left_hit;
        logic              right_hit;
        logic [SEC_W-1:0]  now;
    } item_t;

    // Assemble a command word
    function automatic logic [CMD_W-1:0] pack_cmd(input logic en, input logic [1:0] dir,
                                                  input logic [DUTY_W-1:0] duty,
                                                  input logic [TICKS_W-1:0] ticks);
        return {en, dir, duty, ticks};
    endfunction

endpackage

// ===== hdl/zone_step_steering_sequencer.sv =====
// Zone-step steering sequencer.
// Input stream (s_tvalid/s_tready/s_tdata) carries one control tick per
// transaction: target x, current time and time of the last target update.
// Output stream (m_tvalid/m_tready/m_tdata) carries zero or one 32-bit
// command word per tick, in tick order.
// A classifier sorts each accepted tick (zone, data age, search limits) and
// pushes it into a two-entry queue; an executor pops it, updates the step
// count, return mode, direction, zone and timeout state, and loads the
// output register.
// A tick is written into the queue at the edge that accepts it; its command word is
// loaded into the output register when the executor pops it. Throughput: one tick per
// cycle while m_tready does not hold the output; the queue keeps s_tready high while a result waits.
// When m_tready is low the output register holds its word, the executor
// stops popping, and s_tready drops once the queue holds two ticks.
// Reset clears all steering state and loads the default register values.
// Registers are written through cfg_wen/cfg_index/cfg_wdata; the user must write them only while idle (not enforced).
module zone_step_steering_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_position [16:0], now_seconds [48:17], last_update_seconds [80:49]
    input  logic [zsss_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // command_word [31:0]
    output logic [zsss_pkg::CMD_W-1:0]      m_tdata,
    input  logic                            cfg_wen,
    input  logic [zsss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [zsss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    zsss_pkg::cfg_t  cfg_reg, cfg_next;
    zsss_pkg::item_t front_item;
    zsss_pkg::item_t back_item;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;
    logic            push;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                zsss_pkg::REG_STEER_DUTY:
                    cfg_next.steer_duty = cfg_wdata[zsss_pkg::DUTY_W-1:0];
                zsss_pkg::REG_PULSE_TICKS:
                    cfg_next.pulse_ticks = cfg_wdata[zsss_pkg::TICKS_W-1:0];
                zsss_pkg::REG_STALE_LIMIT:
                    cfg_next.stale_limit = cfg_wdata[zsss_pkg::LIM_W-1:0];
                zsss_pkg::REG_STOP_HOLD:
                    cfg_next.stop_hold = cfg_wdata[zsss_pkg::LIM_W-1:0];
                zsss_pkg::REG_SEARCH_LEFT:
                    cfg_next.search_left = cfg_wdata[zsss_pkg::X_W-1:0];
                zsss_pkg::REG_SEARCH_RIGHT:
                    cfg_next.search_right = cfg_wdata[zsss_pkg::X_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_duty   <= zsss_pkg::DUTY_RESET;
            cfg_reg.pulse_ticks  <= zsss_pkg::TICKS_RESET;
            cfg_reg.stale_limit  <= zsss_pkg::STALE_RESET;
            cfg_reg.stop_hold    <= zsss_pkg::HOLD_RESET;
            cfg_reg.search_left  <= zsss_pkg::SEARCH_LEFT_RESET;
            cfg_reg.search_right <= zsss_pkg::SEARCH_RIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify incoming ticks
    zsss_front u_front (
        .tdata (s_tdata),
        .cfg   (cfg_reg),
        .item  (front_item)
    );

    // Decouple classifier and executor
    zsss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (back_item)
    );

    // Execute ticks and drive the command stream
    zsss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_not_empty),
        .item       (back_item),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cmd    (m_tdata)
    );

endmodule

// ===== hdl/zsss_front.sv =====
module zsss_front (
    input  logic [zsss_pkg::IN_TDATA_W-1:0] tdata,
    input  zsss_pkg::cfg_t                  cfg,
    output zsss_pkg::item_t                 item
);

    logic [zsss_pkg::X_W-1:0]   x;
    logic [zsss_pkg::SEC_W-1:0] now;
    logic [zsss_pkg::SEC_W-1:0] last;
    logic [zsss_pkg::SEC_W:0]   age;
    logic signed [3:0]          zone;

    assign x    = tdata[zsss_pkg::X_W-1:0];
    assign now  = tdata[zsss_pkg::X_W +: zsss_pkg::SEC_W];
    assign last = tdata[zsss_pkg::X_W + zsss_pkg::SEC_W +: zsss_pkg::SEC_W];

    // Signed data age; a negative age counts as fresh
    assign age = {1'b0, now} - {1'b0, last};

    // Sort x into a zone around the centre band
    always_comb
    begin
        if (x >= zsss_pkg::CENTER_LO && x <= zsss_pkg::CENTER_HI)
            zone = 4'sd0;
        else if (x < zsss_pkg::ZONE_B1)
            zone = -4'sd4;
        else if (x < zsss_pkg::ZONE_B2)
            zone = -4'sd3;
        else if (x < zsss_pkg::ZONE_B3)
            zone = -4'sd2;
        else if (x < zsss_pkg::CENTER_LO)
            zone = -4'sd1;
        else if (x < zsss_pkg::ZONE_B5)
            zone = 4'sd1;
        else if (x < zsss_pkg::ZONE_B6)
            zone = 4'sd2;
        else if (x < zsss_pkg::ZONE_B7)
            zone = 4'sd3;
        else if (x <= zsss_pkg::X_ONE)
            zone = 4'sd4;
        else
            zone = 4'sd0;
    end

    // Build the classified transaction
    always_comb
    begin
        item.fresh     = $signed(age) < $signed({{(zsss_pkg::SEC_W + 1 - zsss_pkg::LIM_W){1'b0}},
                                                 cfg.stale_limit});
        item.zone      = zone;
        item.zone_mag  = zone[3] ? 3'(-zone) : zone[2:0];
        item.left_hit  = x <= cfg.search_left;
        item.right_hit = x >= cfg.search_right;
        item.now       = now;
    end

endmodule

// ===== hdl/zsss_queue.sv =====
module zsss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  zsss_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output zsss_pkg::item_t pop_item
);

    zsss_pkg::item_t mem [zsss_pkg::QDEPTH];

    logic [zsss_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [zsss_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [zsss_pkg::QCOUNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == zsss_pkg::QCOUNT_W'(zsss_pkg::QDEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? zsss_pkg::QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? zsss_pkg::QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming transaction
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== hdl/zsss_back.sv =====
`include "zone_step_steering_sequencer_defines.svh"

module zsss_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  zsss_pkg::cfg_t             cfg,
    input  logic                       item_valid,
    input  zsss_pkg::item_t            item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [zsss_pkg::CMD_W-1:0] out_cmd
);

    logic [zsss_pkg::COUNT_BITS-1:0] step_count_reg, step_count_next;
    logic                            returning_reg, returning_next;
    logic [1:0]                      last_dir_reg, last_dir_next;
    logic signed [3:0]               held_zone_reg, held_zone_next;
    logic [zsss_pkg::SEC_W-1:0]      tb_reg, tb_next;
    logic                            out_valid_reg, out_valid_next;
    logic [zsss_pkg::CMD_W-1:0]      out_cmd_reg, out_cmd_next;

    logic [2:0]                 prev_mag;
    logic [1:0]                 fwd_dir;
    logic [1:0]                 ret_dir;
    logic [zsss_pkg::SEC_W-1:0] tb_eff;
    logic [zsss_pkg::SEC_W:0]   hold_age;
    logic                       in_hold;
    logic                       emit;

    // Take the next transaction when the output slot is free
    assign pop       = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_cmd   = out_cmd_reg;

    assign prev_mag = held_zone_reg[3] ? 3'(-held_zone_reg) : held_zone_reg[2:0];
    assign fwd_dir  = item.zone[3] ? zsss_pkg::DIR_LEFT : zsss_pkg::DIR_RIGHT;
    assign ret_dir  = (last_dir_reg == zsss_pkg::DIR_RIGHT) ? zsss_pkg::DIR_LEFT :
                      (last_dir_reg == zsss_pkg::DIR_LEFT)  ? zsss_pkg::DIR_RIGHT :
                                                              zsss_pkg::DIR_NONE;

    // Timeout start latches on the first stale tick
    assign tb_eff   = (tb_reg == '0) ? item.now : tb_reg;
    assign hold_age = {1'b0, item.now} - {1'b0, tb_eff};
    assign in_hold  = $signed(hold_age) < $signed({{(zsss_pkg::SEC_W + 1 - zsss_pkg::LIM_W){1'b0}},
                                                   cfg.stop_hold});

    // Execute one tick against the steering state
    always_comb
    begin
        step_count_next = step_count_reg;
        returning_next  = returning_reg;
        last_dir_next   = last_dir_reg;
        held_zone_next  = held_zone_reg;
        tb_next         = tb_reg;
        emit            = 1'b0;
        out_cmd_next    = out_cmd_reg;
        if (pop)
        begin
            if (item.fresh)
            begin
                tb_next = '0;
                if (!returning_reg)
                begin
                    if (item.zone != 4'sd0 && item.zone_mag > prev_mag)
                    begin
                        if (step_count_reg != '1)
                            step_count_next = step_count_reg + 1'b1;
                        last_dir_next  = fwd_dir;
                        held_zone_next = item.zone;
                        emit           = 1'b1;
                        out_cmd_next   = zsss_pkg::pack_cmd(1'b1, fwd_dir, cfg.steer_duty,
                                                            cfg.pulse_ticks);
                    end
                    else if (item.zone == 4'sd0 && step_count_reg != '0)
                        returning_next = 1'b1;
                    else if (item.zone != 4'sd0 && item.zone_mag < prev_mag)
                        held_zone_next = item.zone;
                end
                else if (step_count_reg != '0 && ret_dir != zsss_pkg::DIR_NONE)
                begin
                    step_count_next = step_count_reg - 1'b1;
                    emit            = 1'b1;
                    out_cmd_next    = zsss_pkg::pack_cmd(1'b1, ret_dir, cfg.steer_duty,
                                                         cfg.pulse_ticks);
                end
                else
                begin
                    returning_next = 1'b0;
                    held_zone_next = 4'sd0;
                end
            end
            else
            begin
                tb_next = tb_eff;
                if (in_hold)
                begin
                    emit         = 1'b1;
                    out_cmd_next = zsss_pkg::pack_cmd(1'b0, zsss_pkg::DIR_NONE, '0,
                                                      cfg.pulse_ticks);
                end
                else if (item.left_hit)
                begin
                    emit         = 1'b1;
                    out_cmd_next = zsss_pkg::pack_cmd(1'b1, zsss_pkg::DIR_LEFT, cfg.steer_duty,
                                                      cfg.pulse_ticks);
                end
                else if (item.right_hit)
                begin
                    emit         = 1'b1;
                    out_cmd_next = zsss_pkg::pack_cmd(1'b1, zsss_pkg::DIR_RIGHT,
                                                      cfg.steer_duty, cfg.pulse_ticks);
                end
            end
        end
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            returning_reg  <= 1'b0;
            last_dir_reg   <= zsss_pkg::DIR_NONE;
            held_zone_reg  <= 4'sd0;
            tb_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_count_reg <= step_count_next;
            returning_reg  <= returning_next;
            last_dir_reg   <= last_dir_next;
            held_zone_reg  <= held_zone_next;
            tb_reg         <= tb_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cmd_reg <= out_cmd_next;
    end

    // Return mode ends on a fresh tick once the count is spent
    `ZSSS_ASSERT_NXT(a_return_exit, pop && item.fresh && returning_reg && step_count_reg == '0,
                     !returning_reg, "return mode did not end with an empty step count")
    // A fresh tick clears the timeout start
    `ZSSS_ASSERT_NXT(a_timeout_clear, pop && item.fresh, tb_reg == '0,
                     "timeout start not cleared by fresh tick")
    // Stale ticks never touch the step count
    `ZSSS_ASSERT_NXT(a_stale_count, pop && !item.fresh, $stable(step_count_reg),
                     "step count changed on a stale tick")

endmodule

// ===== tb/sv/zone_step_steering_sequencer_tb.sv =====
`timescale 1ns / 1ps

module zone_step_steering_sequencer_tb;

    import zsss_pkg::*;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int IDLE_PCT      = 38;
    localparam int STALL_AT      = 400;
    localparam int STALL_CYCLES  = 80;
    localparam int CALM_FROM     = 1200;
    localparam int CALM_TO       = 1500;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int X_MAX         = 131071;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CMD_W-1:0]      m_tdata;
    logic                  cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Ticks waiting to be offered and command words still owed by the block
    logic [IN_TDATA_W-1:0] tick_queue[$];
    logic [CMD_W-1:0]      expected_words[$];
    logic [CMD_W-1:0]      predicted_word;

    int accepted_ticks = 0;
    int queued_ticks = 0;
    int error_count = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    logic [SEC_W-1:0] wall = 32'd1000;
    logic calm;

    // Register copies
    logic [DUTY_W-1:0]  duty_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [LIM_W-1:0]   stale_reg;
    logic [LIM_W-1:0]   hold_reg;
    logic [X_W-1:0]     left_reg;
    logic [X_W-1:0]     right_reg;

    // Steering state
    logic [COUNT_BITS-1:0] steps;
    bit                    returning_mode;
    logic [1:0]            last_dir;
    int                    held_zone;
    logic [SEC_W-1:0]      stop_begin;

    assign calm = (accepted_ticks >= CALM_FROM) && (accepted_ticks < CALM_TO);

    zone_step_steering_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Steering predictor
    // ---------------------------------------------------------------

    function automatic int zone_of_x(input logic [X_W-1:0] x);
        if (x >= CENTER_LO && x <= CENTER_HI) return 0;
        if (x < ZONE_B1) return -4;
        if (x < ZONE_B2) return -3;
        if (x < ZONE_B3) return -2;
        if (x < CENTER_LO) return -1;
        if (x < ZONE_B5) return 1;
        if (x < ZONE_B6) return 2;
        if (x < ZONE_B7) return 3;
        if (x <= X_ONE) return 4;
        // beyond 1.0 behaves like the centre band
        return 0;
    endfunction

    function automatic int zone_mag(input int z);
        return (z < 0) ? -z : z;
    endfunction

    function automatic logic [CMD_W-1:0] steer_word(input logic en, input logic [1:0] dir,
                                                    input logic [DUTY_W-1:0] duty);
        return {en, dir, duty, ticks_reg};
    endfunction

    // Advance the steering state by one tick; return 1 when a command is due
    function automatic bit advance_sequencer(input logic [X_W-1:0] x,
                                             input logic [SEC_W-1:0] now,
                                             input logic [SEC_W-1:0] last,
                                             output logic [CMD_W-1:0] word);
        longint now_l;
        longint last_l;
        longint begin_l;
        int zone;
        logic [1:0] back_dir;
        now_l = now;
        last_l = last;
        word = '0;
        if (now_l - last_l < longint'(stale_reg))
        begin
            // fresh data: zone stepping and return mode
            zone = zone_of_x(x);
            stop_begin = '0;
            if (!returning_mode)
            begin
                if (zone != 0 && zone_mag(zone) > zone_mag(held_zone))
                begin
                    if (steps != '1)
                        steps = steps + 1'b1;
                    last_dir = (zone > 0) ? DIR_RIGHT : DIR_LEFT;
                    held_zone = zone;
                    word = steer_word(1'b1, last_dir, duty_reg);
                    return 1'b1;
                end
                if (zone == 0 && steps != '0)
                    returning_mode = 1'b1;
                else if (zone != 0 && zone_mag(zone) < zone_mag(held_zone))
                    held_zone = zone;
                return 1'b0;
            end
            back_dir = (last_dir == DIR_RIGHT) ? DIR_LEFT :
                       (last_dir == DIR_LEFT) ? DIR_RIGHT : DIR_NONE;
            if (steps != '0 && back_dir != DIR_NONE)
            begin
                steps = steps - 1'b1;
                word = steer_word(1'b1, back_dir, duty_reg);
                return 1'b1;
            end
            returning_mode = 1'b0;
            held_zone = 0;
            return 1'b0;
        end
        // stale data: full stop first, then search from x
        if (stop_begin == '0)
            stop_begin = now;
        begin_l = stop_begin;
        if (now_l - begin_l < longint'(hold_reg))
        begin
            word = steer_word(1'b0, DIR_NONE, '0);
            return 1'b1;
        end
        if (x <= left_reg)
        begin
            word = steer_word(1'b1, DIR_LEFT, duty_reg);
            return 1'b1;
        end
        if (x >= right_reg)
        begin
            word = steer_word(1'b1, DIR_RIGHT, duty_reg);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_STEER_DUTY:   duty_reg = data[DUTY_W-1:0];
            REG_PULSE_TICKS:  ticks_reg = data[TICKS_W-1:0];
            REG_STALE_LIMIT:  stale_reg = data[LIM_W-1:0];
            REG_STOP_HOLD:    hold_reg = data[LIM_W-1:0];
            REG_SEARCH_LEFT:  left_reg = data[X_W-1:0];
            REG_SEARCH_RIGHT: right_reg = data[X_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [CMD_W-1:0] got,
                                   input logic [CMD_W-1:0] want);
        $display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic push_tick(input logic [X_W-1:0] x, input logic [SEC_W-1:0] now,
                             input logic [SEC_W-1:0] last);
        tick_queue.push_back({7'd0, last, now, x});
        queued_ticks++;
    endtask

    function automatic logic [X_W-1:0] x_for_zone(input int z);
        case (z)
            -4: return X_W'($urandom_range(int'(ZONE_B1) - 1, 0));
            -3: return X_W'($urandom_range(int'(ZONE_B2) - 1, int'(ZONE_B1)));
            -2: return X_W'($urandom_range(int'(ZONE_B3) - 1, int'(ZONE_B2)));
            -1: return X_W'($urandom_range(int'(CENTER_LO) - 1, int'(ZONE_B3)));
            0:
            begin
                if ($urandom_range(3) == 0)
                    return X_W'($urandom_range(X_MAX, int'(X_ONE) + 1));
                return X_W'($urandom_range(int'(CENTER_HI), int'(CENTER_LO)));
            end
            1: return X_W'($urandom_range(int'(ZONE_B5) - 1, int'(CENTER_HI) + 1));
            2: return X_W'($urandom_range(int'(ZONE_B6) - 1, int'(ZONE_B5)));
            3: return X_W'($urandom_range(int'(ZONE_B7) - 1, int'(ZONE_B6)));
            default: return X_W'($urandom_range(int'(X_ONE), int'(ZONE_B7)));
        endcase
    endfunction

    // Tick whose data age stays under the stale limit (negative age when the limit is zero)
    task automatic fresh_tick(input logic [X_W-1:0] x);
        logic [SEC_W-1:0] last;
        wall = wall + $urandom_range(1, 0);
        if (stale_reg == '0 || $urandom_range(9) == 0)
            last = wall + $urandom_range(1000, 1);
        else
            last = wall - $urandom_range(int'(stale_reg) - 1, 0);
        push_tick(x, wall, last);
    endtask

    // Walk out through the zones on one side, then usually back to the centre
    task automatic excursion();
        int side;
        int peak;
        side = ($urandom_range(1) == 1) ? 1 : -1;
        peak = $urandom_range(4, 1);
        for (int m = 1; m <= peak; m++)
        begin
            fresh_tick(x_for_zone(side * m));
            if ($urandom_range(3) == 0)
                fresh_tick(x_for_zone(side * $urandom_range(m, 1)));
        end
        if ($urandom_range(9) < 7)
        begin
            fresh_tick(x_for_zone(0));
            repeat (peak + $urandom_range(2, 0))
                fresh_tick(X_W'($urandom_range(X_MAX, 0)));
        end
    endtask

    // Freeze the update time so the data goes stale, then keep ticking
    task automatic stale_episode();
        logic [SEC_W-1:0] last_s;
        logic [X_W-1:0] x;
        last_s = wall - stale_reg - $urandom_range(3, 0);
        repeat ($urandom_range(12, 2))
        begin
            wall = wall + (($urandom_range(7) == 0) ? int'(hold_reg) : $urandom_range(2, 0));
            case ($urandom_range(3))
                0: x = X_W'($urandom_range(int'(left_reg), 0));
                1: x = X_W'($urandom_range(X_MAX, int'(right_reg)));
                default: x = X_W'($urandom_range(X_MAX, 0));
            endcase
            push_tick(x, wall, last_s);
        end
    endtask

    task automatic random_phase(input int n);
        int target;
        target = queued_ticks + n;
        while (queued_ticks < target)
        begin
            case ($urandom_range(99)) inside
                [0:54]:  excursion();
                [55:74]: stale_episode();
                [75:89]: push_tick(X_W'($urandom_range(X_MAX, 0)), $urandom(), $urandom());
                default: fresh_tick(X_W'($urandom_range(X_MAX, 0)));
            endcase
        end
    endtask

    // Write one register with random junk above its width
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int width,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] data;
        mask = (21'd1 << width) - 21'd1;
        data = (value & mask) | (CFG_DATA_W'($urandom()) & ~mask);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        store_reg(idx, data);
    endtask

    task automatic configure(input int phase);
        case (phase)
            0:
            begin
                write_reg(REG_STEER_DUTY, DUTY_W, CFG_DATA_W'(DUTY_RESET));
                write_reg(REG_PULSE_TICKS, TICKS_W, CFG_DATA_W'(TICKS_RESET));
                write_reg(REG_STALE_LIMIT, LIM_W, CFG_DATA_W'(STALE_RESET));
                write_reg(REG_STOP_HOLD, LIM_W, CFG_DATA_W'(HOLD_RESET));
                write_reg(REG_SEARCH_LEFT, X_W, CFG_DATA_W'(SEARCH_LEFT_RESET));
                write_reg(REG_SEARCH_RIGHT, X_W, CFG_DATA_W'(SEARCH_RIGHT_RESET));
            end
            1:
            begin
                write_reg(REG_STEER_DUTY, DUTY_W, '0);
                write_reg(REG_PULSE_TICKS, TICKS_W, '0);
                write_reg(REG_STALE_LIMIT, LIM_W, '0);
                write_reg(REG_STOP_HOLD, LIM_W, '0);
                write_reg(REG_SEARCH_LEFT, X_W, '0);
                write_reg(REG_SEARCH_RIGHT, X_W, '0);
            end
            2:
            begin
                write_reg(REG_STEER_DUTY, DUTY_W, '1);
                write_reg(REG_PULSE_TICKS, TICKS_W, '1);
                write_reg(REG_STALE_LIMIT, LIM_W, '1);
                write_reg(REG_STOP_HOLD, LIM_W, '1);
                write_reg(REG_SEARCH_LEFT, X_W, '1);
                write_reg(REG_SEARCH_RIGHT, X_W, '1);
            end
            default:
            begin
                write_reg(REG_STEER_DUTY, DUTY_W, CFG_DATA_W'($urandom()));
                write_reg(REG_PULSE_TICKS, TICKS_W, CFG_DATA_W'($urandom()));
                write_reg(REG_STALE_LIMIT, LIM_W, CFG_DATA_W'($urandom_range(12, 1)));
                write_reg(REG_STOP_HOLD, LIM_W, CFG_DATA_W'($urandom_range(12, 0)));
                write_reg(REG_SEARCH_LEFT, X_W,
                          CFG_DATA_W'($urandom_range(int'(X_ONE), 0)));
                write_reg(REG_SEARCH_RIGHT, X_W, CFG_DATA_W'($urandom_range(X_MAX, 32768)));
            end
        endcase
        // writes to unused indexes must leave every register alone
        write_reg(($urandom_range(1) == 1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DATA_W,
                  CFG_DATA_W'($urandom()));
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Hold until nothing is queued, offered or owed, then let the pipeline empty
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || s_tvalid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Driver: offer queued ticks, predict on each transaction
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                accepted_ticks <= accepted_ticks + 1;
                if (advance_sequencer(s_tdata[X_W-1:0], s_tdata[X_W+SEC_W-1:X_W],
                                      s_tdata[X_W+2*SEC_W-1:X_W+SEC_W], predicted_word))
                    expected_words.push_back(predicted_word);
            end
            if (!s_tvalid || s_tready)
            begin
                if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tick_queue.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver ready: random stalls plus one long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!stall_done && accepted_ticks >= STALL_AT)
        begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // ---------------------------------------------------------------
    // Monitor: compare each command transaction with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected command_word", m_tdata, '0);
            else
            begin
                if (m_tdata !== expected_words[0])
                    report_mismatch("command_word", m_tdata, expected_words[0]);
                expected_words.delete(0);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("zone_step_steering_sequencer regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        duty_reg = DUTY_RESET;
        ticks_reg = TICKS_RESET;
        stale_reg = STALE_RESET;
        hold_reg = HOLD_RESET;
        left_reg = SEARCH_LEFT_RESET;
        right_reg = SEARCH_RIGHT_RESET;
        steps = '0;
        returning_mode = 1'b0;
        last_dir = DIR_NONE;
        held_zone = 0;
        stop_begin = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Zone edges, return mode, out-of-range x, negative age, full stop and search
        push_tick('0, 32'd100, 32'd100);
        push_tick(X_ONE, 32'd100, 32'd99);
        push_tick(CENTER_LO, 32'd101, 32'd100);
        push_tick(17'd20000, 32'd101, 32'd101);
        push_tick(17'd20000, 32'd102, 32'd101);
        push_tick(CENTER_HI, 32'd102, 32'd102);
        push_tick(X_MAX, 32'd103, 32'd102);
        push_tick(ZONE_B5, 32'd103, 32'd103);
        push_tick(ZONE_B5 - 17'd1, 32'd104, 32'd104);
        push_tick(ZONE_B7, 32'd104, 32'd104);
        push_tick(ZONE_B3, 32'd10, 32'hFFFF_FFF0);
        push_tick(17'd100, 32'd1000, 32'd990);
        push_tick(17'd100, 32'd1002, 32'd990);
        push_tick(SEARCH_LEFT_RESET, 32'd1003, 32'd990);
        push_tick(SEARCH_RIGHT_RESET, 32'd1004, 32'd990);
        push_tick(17'd30000, 32'd1005, 32'd990);
        push_tick(17'd30000, 32'd1006, 32'd1004);
        push_tick(X_MAX, 32'hFFFF_FFFF, 32'd0);
        push_tick(ZONE_B6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // Timeout that begins at time zero, with a zero stale limit
        write_reg(REG_STALE_LIMIT, LIM_W, '0);
        @(posedge clk);
        cfg_wen <= 1'b0;
        push_tick('0, 32'd0, 32'd0);
        push_tick('0, 32'd5, 32'd0);
        push_tick('0, 32'd9, 32'd0);
        push_tick(17'd70000, 32'd9, 32'd10);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            configure(phase);
            if (phase == 0)
            begin
                // Drive the step count into saturation, then unwind it
                repeat (280)
                begin
                    fresh_tick(x_for_zone(1));
                    fresh_tick(x_for_zone(2));
                end
                fresh_tick(x_for_zone(0));
                repeat (258) fresh_tick(x_for_zone(3));
                random_phase(40);
            end
            else
                random_phase(160);
            wait_idle();
        end

        if (error_count == 0)
            $display("zone_step_steering_sequencer regression: pass");
        else
            $display("zone_step_steering_sequencer regression: fail");
        $finish;
    end

endmodule
